>>> sv/tsr_pkg.sv
// Shared constants, codes, state and command types for the tile scanline renderer.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
package tsr_pkg;

   localparam int SPRITE_COUNT  = 40;
   localparam int LINE_WIDTH    = 160;
   localparam int VISIBLE_LINES = 144;
   localparam int TILE_COUNT    = 384;

   localparam int TILE_BYTES   = TILE_COUNT * 16;
   localparam int MAP_BASE     = 6144;
   localparam int MAP_DEPTH    = 2048;
   localparam int MAP_W        = 11;
   localparam int SPRITE_BYTES = SPRITE_COUNT * 4;
   localparam int GROUPS       = (LINE_WIDTH + 7) / 8;
   localparam int TROW_DEPTH   = TILE_COUNT * 8;
   localparam int TROW_W       = $clog2(TROW_DEPTH);
   localparam int SPR_W        = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
   localparam int ADDR_W       = 13;
   localparam int GRP_W        = 5;
   localparam int PADDR_W      = 5;

   typedef enum logic [1:0] {
      OP_VRAM   = 2'd0,
      OP_SPRITE = 2'd1,
      OP_RENDER = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_LCDC = 3'd0,
      REG_SCY  = 3'd1,
      REG_SCX  = 3'd2,
      REG_BGP  = 3'd3,
      REG_OBP0 = 3'd4,
      REG_OBP1 = 3'd5,
      REG_WY   = 3'd6,
      REG_WX   = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PIX_MAP,
      ST_PIX_TILE,
      ST_PIX_APPLY,
      ST_SPR_ATTR,
      ST_SPR_TILE,
      ST_SPR_APPLY,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic write_vram;
      logic write_spr;
      logic start;
      logic pix_map;
      logic pix_tile;
      logic pix_apply;
      logic spr_attr;
      logic spr_tile;
      logic spr_apply;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic line_ok;
      logic pix_last;
      logic spr_en;
      logic spr_last;
      logic grp_last;
      logic out_free;
   } status_type;

   function automatic logic [1:0] pal(input logic [7:0] p, input logic [1:0] ci);
      logic [1:0] s;
      case (ci)
         2'd0: s = p[1:0];
         2'd1: s = p[3:2];
         2'd2: s = p[5:4];
         2'd3: s = p[7:6];
         default: s = p[1:0];
      endcase
      return s;
   endfunction

endpackage

>>> sv/tsr_ctrl.sv
// Sequencer for the tile scanline renderer: accepts words and steps the datapath.
// Depends on tsr_pkg for state, command and status types.
`timescale 1ns / 1ps
module tsr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_opcode,
   input  tsr_pkg::status_type status,
   output tsr_pkg::cmd_type    cmd
);

   tsr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsr_pkg::ST_IDLE: begin
            if (req_valid && req_opcode == tsr_pkg::OP_RENDER && status.line_ok) begin
               state_in = tsr_pkg::ST_PIX_MAP;
            end
         end
         tsr_pkg::ST_PIX_MAP:  state_in = tsr_pkg::ST_PIX_TILE;
         tsr_pkg::ST_PIX_TILE: state_in = tsr_pkg::ST_PIX_APPLY;
         tsr_pkg::ST_PIX_APPLY: begin
            if (!status.pix_last) begin
               state_in = tsr_pkg::ST_PIX_MAP;
            end else if (status.spr_en) begin
               state_in = tsr_pkg::ST_SPR_ATTR;
            end else begin
               state_in = tsr_pkg::ST_EMIT;
            end
         end
         tsr_pkg::ST_SPR_ATTR: state_in = tsr_pkg::ST_SPR_TILE;
         tsr_pkg::ST_SPR_TILE: state_in = tsr_pkg::ST_SPR_APPLY;
         tsr_pkg::ST_SPR_APPLY: begin
            state_in = status.spr_last ? tsr_pkg::ST_EMIT : tsr_pkg::ST_SPR_ATTR;
         end
         tsr_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.grp_last ? tsr_pkg::ST_IDLE : tsr_pkg::ST_PIX_MAP;
            end
         end
         default: state_in = tsr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == tsr_pkg::ST_IDLE);
      cmd = '0;
      case (state_ff)
         tsr_pkg::ST_IDLE: begin
            cmd.write_vram = req_valid && req_opcode == tsr_pkg::OP_VRAM;
            cmd.write_spr  = req_valid && req_opcode == tsr_pkg::OP_SPRITE;
            cmd.start      = req_valid && req_opcode == tsr_pkg::OP_RENDER && status.line_ok;
         end
         tsr_pkg::ST_PIX_MAP:   cmd.pix_map   = 1'b1;
         tsr_pkg::ST_PIX_TILE:  cmd.pix_tile  = 1'b1;
         tsr_pkg::ST_PIX_APPLY: cmd.pix_apply = 1'b1;
         tsr_pkg::ST_SPR_ATTR:  cmd.spr_attr  = 1'b1;
         tsr_pkg::ST_SPR_TILE:  cmd.spr_tile  = 1'b1;
         tsr_pkg::ST_SPR_APPLY: cmd.spr_apply = 1'b1;
         tsr_pkg::ST_EMIT:      cmd.emit      = status.out_free;
         default: cmd = '0;
      endcase
   end

   a_start_walks: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state_ff == tsr_pkg::ST_PIX_MAP)
      else $error("render start did not enter pixel fetch");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.pix_map, cmd.pix_tile, cmd.pix_apply, cmd.spr_attr,
                cmd.spr_tile, cmd.spr_apply, cmd.emit, cmd.write_vram, cmd.write_spr}))
      else $error("more than one datapath step at once");

   a_emit_to_next: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !status.grp_last |=> state_ff == tsr_pkg::ST_PIX_MAP)
      else $error("group emitted but next group not started");

endmodule

>>> sv/tsr_dp.sv
// Datapath of the tile scanline renderer: registers, video and sprite memories,
// pixel and sprite lanes, result register. Depends on tsr_pkg.
`timescale 1ns / 1ps
module tsr_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  tsr_pkg::cmd_type                   cmd,
   output tsr_pkg::status_type                status,
   input  logic [tsr_pkg::ADDR_W-1:0]         req_address,
   input  logic [7:0]                         req_data,
   input  logic [7:0]                         req_line,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tsr_pkg::GRP_W-1:0]          rsp_pixel_group,
   output logic [15:0]                        rsp_shades,
   output logic                               rsp_last,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tsr_pkg::PADDR_W-1:0]        paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata
);

   logic [7:0] lcdc_ff, scy_ff, scx_ff, bgp_ff, obp0_ff, obp1_ff, wy_ff, wx_ff;
   logic       csr_wr;
   tsr_pkg::reg_index_type csr_idx;

   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = tsr_pkg::reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         lcdc_ff <= '0; scy_ff <= '0; scx_ff <= '0; bgp_ff <= '0;
         obp0_ff <= '0; obp1_ff <= '0; wy_ff <= '0; wx_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            tsr_pkg::REG_LCDC: lcdc_ff <= pwdata[7:0];
            tsr_pkg::REG_SCY:  scy_ff  <= pwdata[7:0];
            tsr_pkg::REG_SCX:  scx_ff  <= pwdata[7:0];
            tsr_pkg::REG_BGP:  bgp_ff  <= pwdata[7:0];
            tsr_pkg::REG_OBP0: obp0_ff <= pwdata[7:0];
            tsr_pkg::REG_OBP1: obp1_ff <= pwdata[7:0];
            tsr_pkg::REG_WY:   wy_ff   <= pwdata[7:0];
            tsr_pkg::REG_WX:   wx_ff   <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         tsr_pkg::REG_LCDC: prdata = {24'd0, lcdc_ff};
         tsr_pkg::REG_SCY:  prdata = {24'd0, scy_ff};
         tsr_pkg::REG_SCX:  prdata = {24'd0, scx_ff};
         tsr_pkg::REG_BGP:  prdata = {24'd0, bgp_ff};
         tsr_pkg::REG_OBP0: prdata = {24'd0, obp0_ff};
         tsr_pkg::REG_OBP1: prdata = {24'd0, obp1_ff};
         tsr_pkg::REG_WY:   prdata = {24'd0, wy_ff};
         tsr_pkg::REG_WX:   prdata = {24'd0, wx_ff};
         default:           prdata = '0;
      endcase
   end

   // counters
   logic [7:0]                  line_ff;
   logic [2:0]                  px_ff;
   logic [tsr_pkg::SPR_W-1:0]   spr_ff;
   logic [tsr_pkg::GRP_W-1:0]   grp_ff;

   assign status.line_ok  = {1'b0, req_line} < 9'(tsr_pkg::VISIBLE_LINES);
   assign status.pix_last = (px_ff == 3'd7);
   assign status.spr_en   = lcdc_ff[1];
   assign status.spr_last = (spr_ff == tsr_pkg::SPR_W'(tsr_pkg::SPRITE_COUNT - 1));
   assign status.grp_last = (grp_ff == tsr_pkg::GRP_W'(tsr_pkg::GROUPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff  <= '0;
         spr_ff <= '0;
         grp_ff <= '0;
      end else begin
         if (cmd.start) begin
            px_ff  <= '0;
            spr_ff <= '0;
            grp_ff <= '0;
         end
         if (cmd.pix_apply) px_ff <= px_ff + 3'd1;
         if (cmd.spr_apply) spr_ff <= status.spr_last ? '0 : spr_ff + tsr_pkg::SPR_W'(1);
         if (cmd.emit) begin
            grp_ff <= grp_ff + tsr_pkg::GRP_W'(1);
            px_ff  <= '0;
            spr_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) line_ff <= req_line;
   end

   // video memories
   logic [7:0] map_mem [tsr_pkg::MAP_DEPTH];
   logic [7:0] tlo_mem [tsr_pkg::TROW_DEPTH];
   logic [7:0] thi_mem [tsr_pkg::TROW_DEPTH];
   logic       map_wr, tile_wr;

   assign map_wr  = cmd.write_vram && {1'b0, req_address} >= 14'(tsr_pkg::MAP_BASE);
   assign tile_wr = cmd.write_vram && {1'b0, req_address} < 14'(tsr_pkg::MAP_BASE)
                    && {1'b0, req_address} < 14'(tsr_pkg::TILE_BYTES);

   // pixel fetch
   logic [7:0] x_pix, pcol, prow;
   logic       pwin, pdraw, pmsel;
   logic [tsr_pkg::MAP_W-1:0] map_addr;
   logic [7:0] map_q_ff;
   logic [2:0] pcol_ff, prow_ff;
   logic       pdraw_ff, ptile_ok_ff;

   assign x_pix = {grp_ff, px_ff};
   assign pwin  = lcdc_ff[5] && line_ff >= wy_ff && ({1'b0, x_pix} + 9'd7 >= {1'b0, wx_ff});
   assign pcol  = pwin ? x_pix + 8'd7 - wx_ff : x_pix + scx_ff;
   assign prow  = pwin ? line_ff - wy_ff : line_ff + scy_ff;
   assign pmsel = pwin ? lcdc_ff[6] : lcdc_ff[3];
   assign pdraw = (pwin || lcdc_ff[0]) && ({1'b0, x_pix} < 9'(tsr_pkg::LINE_WIDTH));
   assign map_addr = {pmsel, prow[7:3], pcol[7:3]};

   logic [8:0] ptile;
   logic       ptile_ok;
   assign ptile    = (lcdc_ff[4] || map_q_ff[7]) ? {1'b0, map_q_ff} : {1'b1, map_q_ff};
   assign ptile_ok = {1'b0, ptile} < 10'(tsr_pkg::TILE_COUNT);

   // sprite attributes
   logic [7:0] spr_mem [4][tsr_pkg::SPRITE_COUNT];
   logic       spr_vld_ff [4][tsr_pkg::SPRITE_COUNT];
   logic [7:0] spr_q_ff [4];
   logic       spr_v_ff [4];
   logic       spr_wr;
   logic [tsr_pkg::SPR_W-1:0] spr_wr_idx;

   assign spr_wr     = cmd.write_spr && {1'b0, req_address} < 14'(tsr_pkg::SPRITE_BYTES);
   assign spr_wr_idx = req_address[2 +: tsr_pkg::SPR_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < 4; b++) begin
            for (int s = 0; s < tsr_pkg::SPRITE_COUNT; s++) spr_vld_ff[b][s] <= 1'b0;
         end
      end else if (spr_wr) begin
         spr_vld_ff[req_address[1:0]][spr_wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < 4; b++) begin
         if (spr_wr && req_address[1:0] == 2'(b)) spr_mem[b][spr_wr_idx] <= req_data;
         if (cmd.spr_attr) begin
            spr_q_ff[b] <= spr_mem[b][spr_ff];
            spr_v_ff[b] <= spr_vld_ff[b][spr_ff];
         end
      end
   end

   logic [7:0] sy, sx, sid, sfl;
   logic [9:0] sdiff;
   logic       tall, shit;
   logic [3:0] srow;
   logic [7:0] stile;
   logic       spr_hit_ff;
   logic [7:0] spr_x_ff, spr_fl_ff;

   assign sy    = spr_v_ff[0] ? spr_q_ff[0] : 8'd0;
   assign sx    = spr_v_ff[1] ? spr_q_ff[1] : 8'd0;
   assign sid   = spr_v_ff[2] ? spr_q_ff[2] : 8'd0;
   assign sfl   = spr_v_ff[3] ? spr_q_ff[3] : 8'd0;
   assign tall  = lcdc_ff[2];
   assign sdiff = {2'b0, line_ff} + 10'd16 - {2'b0, sy};
   assign shit  = tall ? (sdiff[9:4] == 6'd0) : (sdiff[9:3] == 7'd0);
   assign srow  = !sfl[6] ? sdiff[3:0] : (tall ? ~sdiff[3:0] : {1'b0, ~sdiff[2:0]});
   assign stile = tall ? {sid[7:1], srow[3]} : sid;

   // shared pattern read
   logic [tsr_pkg::TROW_W-1:0] pat_addr, tile_wr_addr;
   logic [7:0] pat_lo_ff, pat_hi_ff;

   assign pat_addr = cmd.spr_tile ? tsr_pkg::TROW_W'({stile, srow[2:0]})
                                  : tsr_pkg::TROW_W'({ptile, prow_ff});
   assign tile_wr_addr = tsr_pkg::TROW_W'(req_address[12:1]);

   always_ff @(posedge clock) begin
      if (map_wr) map_mem[req_address[tsr_pkg::MAP_W-1:0]] <= req_data;
      if (tile_wr && !req_address[0]) tlo_mem[tile_wr_addr] <= req_data;
      if (tile_wr && req_address[0])  thi_mem[tile_wr_addr] <= req_data;
      if (cmd.pix_map) map_q_ff <= map_mem[map_addr];
      if ((cmd.pix_tile && ptile_ok) || cmd.spr_tile) begin
         pat_lo_ff <= tlo_mem[pat_addr];
         pat_hi_ff <= thi_mem[pat_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pix_map) begin
         pcol_ff  <= pcol[2:0];
         prow_ff  <= prow[2:0];
         pdraw_ff <= pdraw;
      end
      if (cmd.pix_tile) ptile_ok_ff <= ptile_ok;
      if (cmd.spr_tile) begin
         spr_hit_ff <= shit;
         spr_x_ff   <= sx;
         spr_fl_ff  <= sfl;
      end
   end

   // lanes
   logic [1:0] cidx_ff [8];
   logic [1:0] shade_ff [8];
   logic [1:0] pci;
   logic [2:0] pbit;

   assign pbit = ~pcol_ff;
   assign pci  = (pdraw_ff && ptile_ok_ff) ? {pat_hi_ff[pbit], pat_lo_ff[pbit]} : 2'd0;

   always_ff @(posedge clock) begin
      logic [7:0] lx;
      logic [9:0] d;
      logic [2:0] b;
      logic [1:0] ci;
      if (cmd.pix_apply) begin
         cidx_ff[px_ff]  <= pci;
         shade_ff[px_ff] <= pdraw_ff ? tsr_pkg::pal(bgp_ff, pci) : 2'd0;
      end
      if (cmd.spr_apply) begin
         for (int k = 0; k < 8; k++) begin
            lx = {grp_ff, 3'(k)};
            d  = {2'b0, lx} + 10'd8 - {2'b0, spr_x_ff};
            b  = spr_fl_ff[5] ? d[2:0] : ~d[2:0];
            ci = {pat_hi_ff[b], pat_lo_ff[b]};
            if (spr_hit_ff && d[9:3] == 7'd0 && {1'b0, lx} < 9'(tsr_pkg::LINE_WIDTH)
                && ci != 2'd0 && !(spr_fl_ff[7] && cidx_ff[k] != 2'd0)) begin
               shade_ff[k] <= tsr_pkg::pal(spr_fl_ff[4] ? obp1_ff : obp0_ff, ci);
            end
         end
      end
   end

   // result register
   logic                        rsp_valid_ff;
   logic [tsr_pkg::GRP_W-1:0]   rsp_group_ff;
   logic [15:0]                 rsp_shades_ff;
   logic                        rsp_last_ff;

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_group_ff  <= grp_ff;
         rsp_last_ff   <= status.grp_last;
         rsp_shades_ff <= {shade_ff[7], shade_ff[6], shade_ff[5], shade_ff[4],
                           shade_ff[3], shade_ff[2], shade_ff[1], shade_ff[0]};
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_group = rsp_group_ff;
   assign rsp_shades      = rsp_shades_ff;
   assign rsp_last        = rsp_last_ff;

   a_last_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_pixel_group == tsr_pkg::GRP_W'(tsr_pkg::GROUPS - 1))
      else $error("last flag on wrong group");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   a_group_order: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !status.grp_last |=> grp_ff == $past(grp_ff) + tsr_pkg::GRP_W'(1))
      else $error("group counter skipped");

endmodule

>>> sv/tile_scanline_renderer_core.sv
// Top level of the tile scanline renderer: sequencer plus datapath.
// Depends on tsr_pkg, tsr_ctrl and tsr_dp.
//
//   channel   ports                                        direction
//   req       req_valid/ready, opcode, address, data, line in
//   rsp       rsp_valid/ready, pixel_group, shades, last  out
//   csr       psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A write word is done when it is taken. A render word steps through the pixel groups in turn:
// each pixel goes through map read, pattern read and merge one at a time, then with sprites
// on each sprite through attribute read, pattern read and apply, then the group is emitted.
// Synchronous active-high reset clears the csr registers, counters, sprite valid bits, rsp valid
// and control; no clear pass. A stalled rsp holds only the emit step; req is taken only between words.
`timescale 1ns / 1ps
module tile_scanline_renderer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [tsr_pkg::ADDR_W-1:0]    req_address,
   input  logic [7:0]                    req_data,
   input  logic [7:0]                    req_line,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tsr_pkg::GRP_W-1:0]     rsp_pixel_group,
   output logic [15:0]                   rsp_shades,
   output logic                          rsp_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tsr_pkg::PADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   tsr_pkg::cmd_type    cmd;
   tsr_pkg::status_type status;

   assign pready = 1'b1;

   tsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd)
   );

   tsr_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_address     (req_address),
      .req_data        (req_data),
      .req_line        (req_line),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_group (rsp_pixel_group),
      .rsp_shades      (rsp_shades),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata)
   );

endmodule
